// ----- sv/assert_macros.svh -----
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge and
// switched off while the synchronous reset is held low
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ----- sv/dteq_pkg.sv -----
// ------------------------------------------------------------------------
// dteq_pkg
// types, constants and index helpers for the delta timed event queue
// ------------------------------------------------------------------------
`default_nettype none

package dteq_pkg;

  // ring size and derived widths
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int DELTA_W     = 16;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  // one request on the input channel
  typedef struct packed {
    op_t         op;
    logic [3:0]  event_kind;
    logic [15:0] frame_offset;
    logic [31:0] payload_a;
    logic [31:0] payload_b;
    logic [31:0] payload_c;
  } in_item_t;

  // one result on the output channel
  typedef struct packed {
    logic        accepted;
    logic        due_valid;
    logic [3:0]  due_kind;
    logic [31:0] due_a;
    logic [31:0] due_b;
    logic [31:0] due_c;
  } out_item_t;

  // stored event body of one slot
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } slot_body_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic set_pending;
    logic clr_pending;
    logic store_add;
    logic dec_head;
    logic pop_head;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_add;
    logic pending;
    logic head_occ;
    logic next_occ;
    logic head_zero;
  } dp_status_t;

  // ring index step forward with wraparound
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

  // ring index step back with wraparound
  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == '0) begin
      r = IDX_W'(QUEUE_DEPTH - 1);
    end else begin
      r = i - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dteq_ctrl.sv -----
// ------------------------------------------------------------------------
// dteq_ctrl
// two-state sequencer: takes a request, then decides in the execute
// cycle what the datapath does with it from the slot status
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dteq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  output logic                     out_valid,
  input  wire dteq_pkg::dp_status_t status,
  output dteq_pkg::ctrl_cmd_t      cmd
);
  import dteq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.load  = start && !busy;
    if (state_r == ST_EXEC) begin
      cmd.exec = 1'b1;
      if (status.is_add) begin
        cmd.set_pending = 1'b1;
        cmd.store_add   = !status.next_occ;
      end else if (status.pending) begin
        if (!status.head_occ) begin
          cmd.clr_pending = 1'b1;
        end else if (status.head_zero) begin
          cmd.pop_head = 1'b1;
        end else begin
          cmd.dec_head = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // every taken request is executed in the next cycle and then answered
  `ASSERT_NEXT(a_load_then_exec, clk, rst_n, cmd.load, busy)
  `ASSERT_NEXT(a_exec_then_result, clk, rst_n, busy, out_valid && !busy)
  `ASSERT_SAME(a_one_action, clk, rst_n, cmd.exec,
               $countones({cmd.clr_pending, cmd.dec_head, cmd.pop_head,
                           cmd.store_add}) <= 1)

endmodule

`default_nettype wire

// ----- sv/dteq_datapath.sv -----
// ------------------------------------------------------------------------
// dteq_datapath
// slot ring storage, read and write pointers, occupancy bits and the
// delta arithmetic; result register for the output channel
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dteq_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dteq_pkg::in_item_t  in_item,
  input  wire dteq_pkg::ctrl_cmd_t cmd,
  output dteq_pkg::dp_status_t     status,
  output dteq_pkg::out_item_t      out_item
);
  import dteq_pkg::*;

  // delta and body memories
  logic [DELTA_W-1:0] delta_mem [QUEUE_DEPTH];
  slot_body_t         body_mem  [QUEUE_DEPTH];

  in_item_t           item_r;
  logic [DELTA_W-1:0] delta_rd_r;
  slot_body_t         body_rd_r;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               pending_r, pending_nxt;
  logic [QUEUE_DEPTH-1:0] occ_r, occ_nxt;
  out_item_t          out_r, out_nxt;

  logic [IDX_W-1:0]   wr_next, wr_prev, rd_next, delta_rd_addr;
  logic [DELTA_W-1:0] add_delta;
  logic               prev_occ;
  slot_body_t         in_body;

  assign wr_next = idx_next(wr_idx_r);
  assign wr_prev = idx_prev(wr_idx_r);
  assign rd_next = idx_next(rd_idx_r);
  assign prev_occ = occ_r[wr_prev];

  // polls read the head slot, adds read the slot before the tail
  assign delta_rd_addr = (in_item.op == OP_POLL) ? rd_idx_r : wr_prev;

  assign in_body = '{kind: item_r.event_kind, a: item_r.payload_a,
                     b: item_r.payload_b, c: item_r.payload_c};

  // new delta: distance to the previous slot's delta, or the raw offset
  always_comb begin
    if (!prev_occ) begin
      add_delta = item_r.frame_offset;
    end else if (item_r.frame_offset < delta_rd_r) begin
      add_delta = delta_rd_r - item_r.frame_offset;
    end else begin
      add_delta = item_r.frame_offset - delta_rd_r;
    end
  end

  // status to the controller
  assign status.is_add    = (item_r.op == OP_ADD);
  assign status.pending   = pending_r;
  assign status.head_occ  = occ_r[rd_idx_r];
  assign status.next_occ  = occ_r[wr_next];
  assign status.head_zero = (delta_rd_r == '0);

  // request latch and memory reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_item;
      delta_rd_r <= delta_mem[delta_rd_addr];
      body_rd_r  <= body_mem[rd_idx_r];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.store_add) begin
      delta_mem[wr_idx_r] <= add_delta;
      body_mem[wr_idx_r]  <= in_body;
    end else if (cmd.dec_head) begin
      delta_mem[rd_idx_r] <= delta_rd_r - DELTA_W'(1);
    end
  end

  // pointer, flag, occupancy and result next values
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    pending_nxt = pending_r;
    occ_nxt     = occ_r;
    out_nxt     = out_r;
    if (cmd.set_pending) begin
      pending_nxt = 1'b1;
    end
    if (cmd.clr_pending) begin
      pending_nxt = 1'b0;
    end
    if (cmd.store_add) begin
      occ_nxt[wr_idx_r] = 1'b1;
      wr_idx_nxt        = wr_next;
    end
    if (cmd.pop_head) begin
      occ_nxt[rd_idx_r] = 1'b0;
      rd_idx_nxt        = rd_next;
    end
    if (cmd.exec) begin
      out_nxt           = '0;
      out_nxt.accepted  = cmd.store_add;
      out_nxt.due_valid = cmd.pop_head;
      if (cmd.pop_head) begin
        out_nxt.due_kind = body_rd_r.kind;
        out_nxt.due_a    = body_rd_r.a;
        out_nxt.due_b    = body_rd_r.b;
        out_nxt.due_c    = body_rd_r.c;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      pending_r <= 1'b0;
      occ_r     <= '0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      pending_r <= pending_nxt;
      occ_r     <= occ_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_item = out_r;

  // a stored slot is marked occupied, a popped slot is freed
  `ASSERT_NEXT(a_store_marks_occ, clk, rst_n, cmd.store_add, occ_r[$past(wr_idx_r)])
  `ASSERT_NEXT(a_pop_frees_slot, clk, rst_n, cmd.pop_head, !occ_r[$past(rd_idx_r)])
  `ASSERT_NEXT(a_result_kind, clk, rst_n, cmd.exec,
               !(out_r.accepted && out_r.due_valid))

endmodule

`default_nettype wire

// ----- sv/delta_timed_event_queue.sv -----
// ------------------------------------------------------------------------
// delta_timed_event_queue
// ring of timed events stored as deltas; adds append when the slot ahead is
// free, polls count down the head and hand out an event once it falls due
// ------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the request is taken at
//   a rising edge where start is high and busy is low. op selects add or
//   poll.
//   Result channel: each request gives exactly one result, shown on
//   out_item for one cycle while out_valid is high. The receiver cannot
//   stall, so the result must be captured in that cycle.
//   Timing: the request is taken into the execute state, and out_valid
//   and the result are registered at the end of that state. A new
//   request is not taken while busy; busy is high in the cycle after a
//   request is taken, while the slot memory read returns and the head or
//   tail slot is updated through its single write port. The result of
//   one request and the taking of the next can overlap.
//   Reset: synchronous, active low; all slots become empty, both
//   pointers and the pending flag clear. No clearing pass is needed, the
//   block takes requests in the first cycle after reset.
// ------------------------------------------------------------------------
`default_nettype none

module delta_timed_event_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire dteq_pkg::in_item_t in_item,
  output logic                    out_valid,
  output dteq_pkg::out_item_t     out_item
);
  import dteq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  dteq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and arithmetic
  dteq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ----- tb/delta_timed_event_queue_tb.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// delta_timed_event_queue_tb
// drives add and poll requests into the event ring, keeps its own copy of
// the slot deltas, bodies and pointers, and compares every result with
// the one that copy predicts; a directed opening, random bursts of adds,
// polls and mixed requests, and a closing pair of full-range offsets
// ------------------------------------------------------------------------

module delta_timed_event_queue_tb;
  import dteq_pkg::*;

  // ring contents and the results still owed by the block
  class due_event_ledger;
    logic signed [17:0] slot_count [QUEUE_DEPTH];
    slot_body_t         slot_body [QUEUE_DEPTH];
    int                 tail_pos;
    int                 head_pos;
    bit                 pending;
    out_item_t          awaited_results [$];
    int                 error_count;

    function new();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_count[i] = -18'sd1;
        slot_body[i]  = '0;
      end
      tail_pos    = 0;
      head_pos    = 0;
      pending     = 1'b0;
      error_count = 0;
    endfunction

    // apply one accepted request to the ring and queue the result it owes
    function void note_request(in_item_t req);
      int                 nxt;
      int                 prv;
      logic signed [17:0] gap_count;
      out_item_t          res;
      res = '0;
      if (req.op == OP_ADD) begin
        pending = 1'b1;
        nxt = (tail_pos + 1) % QUEUE_DEPTH;
        prv = (tail_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        // dropped when the slot ahead is still occupied
        if (slot_count[nxt] < 0) begin
          gap_count = {2'b00, req.frame_offset};
          if (slot_count[prv] >= 0) begin
            gap_count = (gap_count < slot_count[prv]) ? slot_count[prv] - gap_count
                                                      : gap_count - slot_count[prv];
          end
          slot_count[tail_pos] = gap_count;
          slot_body[tail_pos]  = {req.event_kind, req.payload_a, req.payload_b,
                                  req.payload_c};
          tail_pos     = nxt;
          res.accepted = 1'b1;
        end
      end else if (pending) begin
        if (slot_count[head_pos] < 0) begin
          // nothing at the head: the flag drops
          pending = 1'b0;
        end else begin
          slot_count[head_pos] = slot_count[head_pos] - 18'sd1;
          if (slot_count[head_pos] < 0) begin
            res.due_valid = 1'b1;
            res.due_kind  = slot_body[head_pos].kind;
            res.due_a     = slot_body[head_pos].a;
            res.due_b     = slot_body[head_pos].b;
            res.due_c     = slot_body[head_pos].c;
            head_pos      = (head_pos + 1) % QUEUE_DEPTH;
          end
        end
      end
      awaited_results.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    // compare one result with the oldest one owed
    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
      if (got.due_valid !== want.due_valid)
        report($sformatf("due_valid %b, want %b", got.due_valid, want.due_valid));
      if (got.due_kind !== want.due_kind)
        report($sformatf("due_kind %h, want %h", got.due_kind, want.due_kind));
      if (got.due_a !== want.due_a)
        report($sformatf("due_a %h, want %h", got.due_a, want.due_a));
      if (got.due_b !== want.due_b)
        report($sformatf("due_b %h, want %h", got.due_b, want.due_b));
      if (got.due_c !== want.due_c)
        report($sformatf("due_c %h, want %h", got.due_c, want.due_c));
    endtask
  endclass

  localparam int STALL_LIMIT   = 400;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int TAIL_CYCLES   = 8;
  localparam int LATE_POLLS    = 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        idle_cycles = 0;

  due_event_ledger ledger = new();

  delta_timed_event_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // note taken requests and check results on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) ledger.note_request(in_item);
      if (out_valid) ledger.check_result(out_item);
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_request(op_t op, logic [3:0] kind,
                                            logic [15:0] offset, logic [31:0] a,
                                            logic [31:0] b, logic [31:0] c);
    in_item_t req;
    req.op           = op;
    req.event_kind   = kind;
    req.frame_offset = offset;
    req.payload_a    = a;
    req.payload_b    = b;
    req.payload_c    = c;
    return req;
  endfunction

  // small offsets keep the countdowns short enough to drain
  function automatic in_item_t random_request(op_t op);
    int          r;
    logic [15:0] offset;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      offset = 16'($urandom_range(0, 3));
    end else if (r < 97) begin
      offset = 16'($urandom_range(0, 20));
    end else begin
      offset = 16'($urandom_range(0, 60));
    end
    return make_request(op, 4'($urandom_range(0, 15)), offset, $urandom, $urandom,
                        $urandom);
  endfunction

  // present one request from a falling edge and hold it until taken
  task automatic send_request(input in_item_t req, input int gap);
    in_item <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    in_item_t req;
    op_t      op;
    int       n_items;
    int       sel;
    int       phase_len;
    bit       no_idle;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // poll with the pending flag still clear after reset
    send_request(random_request(OP_POLL), pick_gap());
    // first add sees an empty slot before it, offset stored as given
    send_request(make_request(OP_ADD, 4'h0, 16'h0000, 32'h0, 32'h0, 32'h0), pick_gap());
    // offset above the previous delta, then below, then above again
    send_request(make_request(OP_ADD, 4'hf, 16'h0001, '1, '1, '1), pick_gap());
    send_request(make_request(OP_ADD, 4'h9, 16'h0000, $urandom, $urandom, $urandom),
                 pick_gap());
    send_request(make_request(OP_ADD, 4'h6, 16'h0003, $urandom, $urandom, $urandom),
                 pick_gap());
    // count all four down, then one poll clears the flag and one finds it clear
    repeat (10) send_request(random_request(OP_POLL), pick_gap());

    // random bursts of adds, of polls, and of mixed requests
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      sel     = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 3) == 0);
      if (sel < 4) begin
        phase_len = $urandom_range(1, 70);
      end else if (sel < 8) begin
        phase_len = $urandom_range(1, 120);
      end else begin
        phase_len = $urandom_range(1, 40);
      end
      for (int k = 0; k < phase_len; k++) begin
        if (sel < 4) begin
          op = OP_ADD;
        end else if (sel < 8) begin
          op = OP_POLL;
        end else begin
          op = op_t'($urandom_range(0, 1));
        end
        req = random_request(op);
        n_items++;
        send_request(req, no_idle ? 0 : pick_gap());
      end
    end

    // largest offset, then a zero delta behind it, and a few countdown polls
    send_request(make_request(OP_ADD, 4'h5, 16'hffff, $urandom, $urandom, $urandom), 0);
    send_request(make_request(OP_ADD, 4'ha, 16'hffff, $urandom, $urandom, $urandom), 0);
    repeat (LATE_POLLS) send_request(random_request(OP_POLL), 0);
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    while (ledger.awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.error_count == 0 && ledger.awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
